### design/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared types and codes for the bounded deque with search: operation and
// status codes, the stored word type and the control group sent to the cells.
// ----------------------------------------------------------------------------
package bdqs_pkg;

    typedef logic signed [31:0] word_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // take_prev: shift towards the back, cell 0 loads the pushed value
    // take_next: shift towards the front, the last cell takes cell 0
    // load_back: the cell whose index equals the entry count loads the value
    typedef struct packed {
        logic take_prev;
        logic take_next;
        logic load_back;
    } cell_ctl_t;

endpackage

### design/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Double-ended queue of signed 32-bit words held in a chain of cells, cell 0
// at the front, with push and pop at both ends and a search for a key.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Signals
//  request   start & !busy      op, value
//  result    done (one cycle)   status, popped_value, found, position,
//                               entry_count
//
//  Push front, push back and pop front need no rotation: done follows the
//  transfer in the next cycle and busy stays low. Pop back and search rotate
//  the whole chain once, one cell per cycle; busy is high while the chain
//  rotates and done is registered on the last step; a new request may
//  be taken in the done cycle. Reset empties the deque at once; the cells
//  themselves are not cleared. done is high for one cycle; the result holds.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
    import bdqs_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic               found,
    output logic [3:0]         position,
    output logic [4:0]         entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t        cell_ctl;
    logic [CNT_W-1:0] count;
    word_t            cell_data [CAPACITY];

    bdqs_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .value        (value),
        .head         (cell_data[0]),
        .cell_ctl     (cell_ctl),
        .count        (count),
        .done         (done),
        .status       (status),
        .popped_value (popped_value),
        .found        (found),
        .position     (position),
        .entry_count  (entry_count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t prev_data;
        word_t next_data;

        if (i == 0)
        begin : g_first
            assign prev_data = value;
        end
        else
        begin : g_mid_prev
            assign prev_data = cell_data[i-1];
        end

        // close the ring so a full rotation restores the order
        if (i == CAPACITY - 1)
        begin : g_last
            assign next_data = cell_data[0];
        end
        else
        begin : g_mid_next
            assign next_data = cell_data[i+1];
        end

        bdqs_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk       (clk),
            .cell_ctl  (cell_ctl),
            .count     (count),
            .value     (value),
            .prev_data (prev_data),
            .next_data (next_data),
            .data      (cell_data[i])
        );
    end

endmodule

### design/bdqs_cell.sv
// ----------------------------------------------------------------------------
// bdqs_cell
// One storage cell of the deque chain. Holds the entry at a fixed position
// from the front and takes its neighbour's word on a shift.
// ----------------------------------------------------------------------------
module bdqs_cell
    import bdqs_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
)
(
    input  logic             clk,
    input  cell_ctl_t        cell_ctl,
    input  logic [CNT_W-1:0] count,
    input  word_t            value,
    input  word_t            prev_data,
    input  word_t            next_data,
    output word_t            data
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cell_ctl.take_prev)
        begin
            data_next = prev_data;
        end
        else if (cell_ctl.take_next)
        begin
            data_next = next_data;
        end
        else if (cell_ctl.load_back && (count == CNT_W'(CELL_IDX)))
        begin
            data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### design/bdqs_ctrl.sv
// ----------------------------------------------------------------------------
// bdqs_ctrl
// Sequencer for the deque: decodes requests, keeps the entry count, drives
// the cell chain and walks a full rotation for search and back pop.
// ----------------------------------------------------------------------------
module bdqs_ctrl
    import bdqs_pkg::*;
#(
    parameter  int CAPACITY = 16,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int IDX_W    = $clog2(CAPACITY)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       op,
    input  word_t            value,
    input  word_t            head,
    output cell_ctl_t        cell_ctl,
    output logic [CNT_W-1:0] count,
    output logic             done,
    output logic [1:0]       status,
    output word_t            popped_value,
    output logic             found,
    output logic [3:0]       position,
    output logic [4:0]       entry_count
);

    typedef enum logic {
        S_IDLE,
        S_ROTATE
    } state_t;

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [IDX_W-1:0] step_reg,   step_next;
    word_t            key_reg,    key_next;
    logic             is_pop_reg, is_pop_next;
    logic             done_reg,   done_next;
    status_t          status_reg, status_next;
    word_t            popped_reg, popped_next;
    logic             found_reg,  found_next;
    logic [IDX_W-1:0] pos_reg,    pos_next;

    logic             accept;
    logic             not_full;
    logic             not_empty;
    logic             in_range;
    logic             match;
    logic             last_step;
    logic [31:0]      count_wide;
    logic [31:0]      pos_wide;

    assign accept    = start && (state_reg == S_IDLE);
    assign not_full  = (count_reg != CNT_W'(CAPACITY));
    assign not_empty = (count_reg != '0);
    assign in_range  = (CNT_W'(step_reg) < count_reg);
    assign match     = in_range && !found_reg && (head == key_reg);
    assign last_step = (step_reg == IDX_W'(CAPACITY - 1));

    always_comb
    begin
        cell_ctl.take_prev = accept && (op == OP_PUSH_FRONT) && not_full;
        cell_ctl.load_back = accept && (op == OP_PUSH_BACK) && not_full;
        // rotation and front pop both move every entry one cell to the front
        cell_ctl.take_next = (accept && (op == OP_POP_FRONT) && not_empty)
                             || (state_reg == S_ROTATE);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        key_next    = key_reg;
        is_pop_next = is_pop_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        popped_next = popped_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    popped_next = '0;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    done_next   = 1'b1;
                    case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (not_full)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (not_empty)
                            begin
                                popped_next = head;
                                count_next  = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        OP_POP_BACK, OP_SEARCH:
                        begin
                            if (!not_empty)
                            begin
                                status_next = (op == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                            end
                            else
                            begin
                                // hold the result back until the chain has come full circle
                                done_next   = 1'b0;
                                state_next  = S_ROTATE;
                                step_next   = '0;
                                key_next    = value;
                                is_pop_next = (op == OP_POP_BACK);
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ROTATE:
            begin
                step_next = step_reg + IDX_W'(1);
                if (is_pop_reg)
                begin
                    if (CNT_W'(step_reg) == (count_reg - CNT_W'(1)))
                    begin
                        popped_next = head;
                    end
                end
                else if (match)
                begin
                    found_next = 1'b1;
                    pos_next   = step_reg;
                end
                if (last_step)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (is_pop_reg)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_OK;
                    end
                    else
                    begin
                        status_next = (found_reg || match) ? ST_OK : ST_NOTFOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            key_reg    <= '0;
            is_pop_reg <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            popped_reg <= '0;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            key_reg    <= key_next;
            is_pop_reg <= is_pop_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            popped_reg <= popped_next;
            found_reg  <= found_next;
            pos_reg    <= pos_next;
        end
    end

    assign count_wide = 32'(count_reg);
    assign pos_wide   = 32'(pos_reg);

    assign busy         = (state_reg == S_ROTATE);
    assign count        = count_reg;
    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign position     = pos_wide[3:0];
    assign entry_count  = count_wide[4:0];

endmodule
